// ===== rtl/bss_pkg.sv =====
`timescale 1ns / 1ps
// bss_pkg: shared types and constants for the bounded substring search block
// no dependencies; used by bss_cell, bounded_substring_search, bss_search_checker and tb_top
package bss_pkg;

  localparam int unsigned RegBytes       = 16;
  localparam int unsigned PatternMaxDef  = 16;
  localparam int unsigned IndexBitsDef   = 16;
  localparam int unsigned CfgDataW       = 64;
  localparam int unsigned CfgIdxW        = 2;
  localparam int unsigned PosW           = 16;
  localparam int unsigned PatLenW        = 5;
  localparam int unsigned LimitW         = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PATTERN_LOW  = 2'd0,
    CFG_PATTERN_HIGH = 2'd1,
    CFG_PATTERN_LEN  = 2'd2,
    CFG_SEARCH_LIMIT = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_SEARCH   = 2'd0,
    ST_FOUND    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_DONE     = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       first_of_text;
  } in_beat_t;

  typedef struct packed {
    status_e         status;
    logic [PosW-1:0] match_position;
  } out_beat_t;

  // control handed to every cell of the chain
  typedef struct packed {
    logic adv;
    logic clr;
  } cell_ctrl_t;

endpackage

// ===== rtl/bss_cell.sv =====
`timescale 1ns / 1ps
// bss_cell: one cell of the window chain, holds one recent text byte
// depends on bss_pkg
module bss_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bss_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]          shift_i,
  output logic [7:0]          win_o
);

  logic [7:0] win_q, win_d;

  // byte as seen by this beat, a restart wipes it first
  assign win_o = ctrl_i.clr ? 8'd0 : win_q;

  always_comb begin
    win_d = win_q;
    if (ctrl_i.adv) begin
      win_d = shift_i;
    end else if (ctrl_i.clr) begin
      win_d = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= 8'd0;
    end else begin
      win_q <= win_d;
    end
  end

endmodule

// ===== rtl/bounded_substring_search.sv =====
`timescale 1ns / 1ps
// bounded_substring_search: top level, config registers, chain of window cells, output register
// depends on bss_pkg and bss_cell
// result: registered, valid in the cycle after its text beat is accepted
// throughput: one text byte per cycle while in_stall_o is low, by a combinational compare
// reset: config registers, window bytes, byte offset and concluded flag clear to zero;
//   the output register empties and a search is open right after reset
module bounded_substring_search #(
  parameter int unsigned PATTERN_MAX = bss_pkg::PatternMaxDef,
  parameter int unsigned INDEX_BITS  = bss_pkg::IndexBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bss_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [bss_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  bss_pkg::in_beat_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output bss_pkg::out_beat_t              out_data_o
);

  localparam int unsigned Cap   = (PATTERN_MAX < bss_pkg::RegBytes) ? PATTERN_MAX
                                                                     : bss_pkg::RegBytes;
  localparam int unsigned LenW  = $clog2(Cap + 1);
  localparam int unsigned CmpW  = ((INDEX_BITS > bss_pkg::LimitW) ? INDEX_BITS
                                                                    : bss_pkg::LimitW) + 1;

  // configuration registers
  logic [bss_pkg::CfgDataW-1:0] pattern_low_q, pattern_high_q;
  logic [bss_pkg::PatLenW-1:0]  pattern_length_q;
  logic [bss_pkg::LimitW-1:0]   search_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_low_q    <= '0;
      pattern_high_q   <= '0;
      pattern_length_q <= '0;
      search_limit_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (bss_pkg::cfg_reg_e'(cfg_idx_i))
        bss_pkg::CFG_PATTERN_LOW:  pattern_low_q    <= cfg_wdata_i;
        bss_pkg::CFG_PATTERN_HIGH: pattern_high_q   <= cfg_wdata_i;
        bss_pkg::CFG_PATTERN_LEN:  pattern_length_q <= cfg_wdata_i[bss_pkg::PatLenW-1:0];
        bss_pkg::CFG_SEARCH_LIMIT: search_limit_q   <= cfg_wdata_i[bss_pkg::LimitW-1:0];
        default: ;
      endcase
    end
  end

  logic [2*bss_pkg::CfgDataW-1:0] pat_all;
  assign pat_all = {pattern_high_q, pattern_low_q};

  // effective length: saturate, then cut at the first zero pattern byte
  logic [LenW-1:0] len_sat, eff_len;
  always_comb begin
    if (pattern_length_q > bss_pkg::PatLenW'(Cap)) begin
      len_sat = LenW'(Cap);
    end else begin
      len_sat = pattern_length_q[LenW-1:0];
    end
    eff_len = len_sat;
    for (int k = Cap - 1; k >= 0; k--) begin
      if ((pat_all[8*k +: 8] == 8'd0) && (LenW'(k) < len_sat)) begin
        eff_len = LenW'(k);
      end
    end
  end

  // search state
  logic [INDEX_BITS-1:0] byte_index_q, byte_index_d;
  logic                  concluded_q, concluded_d;

  logic in_acc;
  logic out_valid_q, out_valid_d;
  bss_pkg::out_beat_t out_data_q, out_data_d;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  logic                  first;
  logic [INDEX_BITS-1:0] pos_eff;
  logic                  conc_eff;
  logic [CmpW-1:0]       pos_x, pos1_x, lim_x;
  logic                  len_zero, early_nf, adv;

  assign first    = in_data_i.first_of_text;
  assign pos_eff  = first ? '0 : byte_index_q;
  assign conc_eff = first ? 1'b0 : concluded_q;
  assign pos_x    = CmpW'(pos_eff);
  assign pos1_x   = pos_x + CmpW'(1);
  assign lim_x    = CmpW'(search_limit_q);
  assign len_zero = (eff_len == '0);
  assign early_nf = (in_data_i.text_byte == 8'd0) || (pos_x >= lim_x);
  assign adv      = in_acc && !conc_eff && !len_zero && !early_nf;

  bss_pkg::cell_ctrl_t ctrl;
  assign ctrl.adv = adv;
  assign ctrl.clr = in_acc && first;

  // win_b: window before this beat, shift_b: window with this beat shifted in
  logic [Cap-1:0][7:0] win_b, shift_b;

  for (genvar g = 0; g < Cap; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign shift_b[g] = in_data_i.text_byte;
    end else begin : g_link
      assign shift_b[g] = win_b[g-1];
    end
    bss_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .shift_i(shift_b[g]),
      .win_o  (win_b[g])
    );
  end

  // newest byte sits in cell 0 and lines up with the pattern's last byte
  logic hit;
  always_comb begin
    hit = 1'b1;
    for (int j = 0; j < Cap; j++) begin
      for (int k = 0; k < Cap; k++) begin
        if ((j + k + 1 == int'(eff_len)) && (shift_b[j] != pat_all[8*k +: 8])) begin
          hit = 1'b0;
        end
      end
    end
    hit = hit && (pos1_x >= CmpW'(eff_len));
  end

  always_comb begin
    byte_index_d = byte_index_q;
    concluded_d  = concluded_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_data_d   = out_data_q;
    if (in_acc) begin
      out_valid_d               = 1'b1;
      out_data_d.status         = bss_pkg::ST_SEARCH;
      out_data_d.match_position = '0;
      byte_index_d              = pos_eff;
      concluded_d               = conc_eff;
      priority if (conc_eff) begin
        out_data_d.status = bss_pkg::ST_DONE;
      end else if (len_zero) begin
        out_data_d.status = bss_pkg::ST_FOUND;
        concluded_d       = 1'b1;
      end else if (early_nf) begin
        out_data_d.status = bss_pkg::ST_NOTFOUND;
        concluded_d       = 1'b1;
      end else begin
        if (hit) begin
          out_data_d.status         = bss_pkg::ST_FOUND;
          out_data_d.match_position = bss_pkg::PosW'(pos1_x - CmpW'(eff_len));
          concluded_d               = 1'b1;
        end else if (pos1_x >= lim_x) begin
          out_data_d.status = bss_pkg::ST_NOTFOUND;
          concluded_d       = 1'b1;
        end
        // offset saturates at its maximum
        if (pos_eff != '1) begin
          byte_index_d = pos_eff + INDEX_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q <= '0;
      concluded_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      byte_index_q <= byte_index_d;
      concluded_q  <= concluded_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== dv/bss_search_checker.sv =====
`timescale 1ns / 1ps
// bss_search_checker: watches the config port and both beat channels of the search block,
// predicts each result beat from its own model of the search and compares field by field
// depends on bss_pkg
module bss_search_checker
  import bss_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  in_beat_t            in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  out_beat_t           out_data_i,
  output int unsigned         err_count_o,
  output int unsigned         pending_o,
  output int unsigned         examined_o,
  output int unsigned         found_o,
  output int unsigned         not_found_o
);

  localparam int unsigned WinBytes = PatternMaxDef;

  logic [8*RegBytes-1:0]   pattern;
  logic [PatLenW-1:0]      pat_len;
  logic [LimitW-1:0]       limit;
  logic [7:0]              window [WinBytes];
  logic [IndexBitsDef-1:0] offset;
  logic                    concluded;
  out_beat_t               result_q [$];

  function automatic void clear_search();
    window    = '{default: 8'h00};
    offset    = '0;
    concluded = 1'b0;
  endfunction

  // usable pattern bytes: length capped, cut at the first zero byte
  function automatic int unsigned live_length();
    int unsigned cap;
    cap = (pat_len > RegBytes) ? RegBytes : pat_len;
    if (cap > WinBytes) cap = WinBytes;
    for (int unsigned k = 0; k < cap; k++)
      if (pattern[8*k +: 8] == 8'h00) return k;
    return cap;
  endfunction

  function automatic out_beat_t predict_search(in_beat_t beat);
    out_beat_t   res;
    int unsigned len;
    int unsigned pos;
    bit          hit;
    res.status         = ST_SEARCH;
    res.match_position = '0;
    if (beat.first_of_text) clear_search();
    if (concluded) begin
      res.status = ST_DONE;
      return res;
    end
    len = live_length();
    // empty pattern matches on whatever byte comes first
    if (len == 0) begin
      res.status = ST_FOUND;
      concluded  = 1'b1;
      return res;
    end
    pos = offset;
    if (beat.text_byte == 8'h00 || pos >= limit) begin
      res.status = ST_NOTFOUND;
      concluded  = 1'b1;
      return res;
    end
    for (int k = WinBytes - 1; k > 0; k--) window[k] = window[k-1];
    window[0] = beat.text_byte;
    hit = (pos + 1 >= len);
    for (int unsigned k = 0; hit && k < len; k++)
      if (window[len-1-k] != pattern[8*k +: 8]) hit = 1'b0;
    if (hit) begin
      res.status         = ST_FOUND;
      res.match_position = PosW'(pos + 1 - len);
      concluded          = 1'b1;
    end else if (pos + 1 >= limit) begin
      res.status = ST_NOTFOUND;
      concluded  = 1'b1;
    end
    if (offset != '1) offset++;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      pattern     = '0;
      pat_len     = '0;
      limit       = '0;
      clear_search();
      result_q.delete();
      err_count_o = 0;
      pending_o   = 0;
      examined_o  = 0;
      found_o     = 0;
      not_found_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          err_count_o++;
          $display("%0t: result beat with none expected, status %0d position %0d",
                   $time, out_data_i.status, out_data_i.match_position);
        end else begin
          want = result_q.pop_front();
          if (out_data_i.status !== want.status) begin
            err_count_o++;
            $display("%0t: status expected %0d, got %0d",
                     $time, want.status, out_data_i.status);
          end
          if (out_data_i.match_position !== want.match_position) begin
            err_count_o++;
            $display("%0t: match position expected %0d, got %0d",
                     $time, want.match_position, out_data_i.match_position);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PATTERN_LOW:  pattern[63:0]   = cfg_wdata_i;
          CFG_PATTERN_HIGH: pattern[127:64] = cfg_wdata_i;
          CFG_PATTERN_LEN:  pat_len         = cfg_wdata_i[PatLenW-1:0];
          CFG_SEARCH_LIMIT: limit           = cfg_wdata_i[LimitW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        want = predict_search(in_data_i);
        if (want.status != ST_DONE)     examined_o++;
        if (want.status == ST_FOUND)    found_o++;
        if (want.status == ST_NOTFOUND) not_found_o++;
        result_q.push_back(want);
      end
      pending_o = result_q.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for bounded_substring_search
// depends on bss_pkg, the block itself and bss_search_checker
module tb_top;
  import bss_pkg::*;

  localparam int unsigned CycleLimit  = 400_000;
  localparam int unsigned BeatsTarget = 1800;
  localparam int unsigned PhaseCount  = 12;
  localparam int unsigned HoldCycles  = 120;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  cfg_reg_e            cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                in_valid;
  logic                in_stall;
  in_beat_t            in_data;
  logic                out_valid;
  logic                out_stall;
  out_beat_t           out_data;

  int unsigned err_count, pending, examined, found_cnt, not_found_cnt;
  int unsigned in_idle_pct   = 0;
  int unsigned out_stall_pct = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned settings_cnt  = 0;
  int unsigned pat_used      = 0;
  int unsigned sent_cnt      = 0;
  bit          hold_req      = 1'b0;
  logic [7:0]  pat [RegBytes];

  bounded_substring_search u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  bss_search_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .err_count_o (err_count),
    .pending_o   (pending),
    .examined_o  (examined),
    .found_o     (found_cnt),
    .not_found_o (not_found_cnt)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int unsigned hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < out_stall_pct);
      end
    end
  end

  // starts and ends at a falling edge
  task automatic send_beat(input logic [7:0] text_byte, input logic first);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{text_byte: text_byte, first_of_text: first};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_cnt++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // upper bits of the narrow registers carry junk that must be dropped
  task automatic set_config(input logic [63:0] low, input logic [63:0] high,
                            input logic [PatLenW-1:0] len, input logic [LimitW-1:0] lim);
    logic [CfgDataW-1:0] junk;
    junk = {$urandom, $urandom};
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_PATTERN_LOW;
    cfg_wdata <= low;
    @(negedge clk);
    cfg_idx   <= CFG_PATTERN_HIGH;
    cfg_wdata <= high;
    @(negedge clk);
    cfg_idx   <= CFG_PATTERN_LEN;
    cfg_wdata <= {junk[CfgDataW-1:PatLenW], len};
    @(negedge clk);
    cfg_idx   <= CFG_SEARCH_LIMIT;
    cfg_wdata <= {junk[CfgDataW-1:LimitW], lim};
    @(negedge clk);
    cfg_we    <= 1'b0;
    settings_cnt++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], i == 0);
  endtask

  // one text: random bytes, sometimes with the pattern inside, sometimes NUL terminated
  task automatic send_text();
    logic [7:0]  txt [$];
    int unsigned n;
    int unsigned at;
    int unsigned roll;
    n = ($urandom_range(99) < 85) ? $urandom_range(24, 1) : $urandom_range(60, 25);
    for (int unsigned i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 40)      txt.push_back(pat[$urandom_range(RegBytes - 1)]);
      else if (roll < 85) txt.push_back(8'($urandom_range(8'h64, 8'h61)));
      else                txt.push_back(8'($urandom_range(255, 1)));
    end
    if (pat_used > 0 && $urandom_range(99) < 50) begin
      at = $urandom_range(n);
      for (int unsigned k = 0; k < pat_used; k++) txt.insert(at + k, pat[k]);
    end
    if ($urandom_range(99) < 30) txt.push_back(8'h00);
    foreach (txt[i]) send_beat(txt[i], i == 0);
  endtask

  task automatic run_phase(input int unsigned ph);
    int unsigned  len;
    int unsigned  lim;
    int unsigned  roll;
    int unsigned  quota;
    logic [127:0] packed_pat;
    drain();
    in_idle_pct   = (ph % 4 == 1) ? 69 : (ph % 4 == 3) ? 31 : 0;
    out_stall_pct = (ph % 4 == 2) ? 69 : (ph % 4 == 3) ? 31 : 0;
    case (ph)
      0: len = 16;
      1: len = 31;
      2: len = 0;
      3: len = 1;
      default: begin
        roll = $urandom_range(99);
        if (roll < 70)      len = $urandom_range(6, 1);
        else if (roll < 80) len = 0;
        else if (roll < 90) len = 16;
        else                len = $urandom_range(31, 17);
      end
    endcase
    case (ph)
      0, 1: lim = 16'hFFFF;
      4:    lim = 0;
      5:    lim = 1;
      default: begin
        roll = $urandom_range(99);
        if (roll < 60)      lim = $urandom_range(40, 2);
        else if (roll < 80) lim = 16'hFFFF;
        else                lim = $urandom_range(16'hFFFF);
      end
    endcase
    for (int unsigned k = 0; k < RegBytes; k++) begin
      roll   = $urandom_range(99);
      pat[k] = (roll < 75) ? 8'($urandom_range(8'h64, 8'h61)) : 8'($urandom_range(255, 1));
    end
    if (ph > 3 && $urandom_range(99) < 15) pat[$urandom_range(RegBytes - 1)] = 8'h00;
    pat_used = (len > RegBytes) ? RegBytes : len;
    for (int unsigned k = 0; k < pat_used; k++) begin
      if (pat[k] == 8'h00) begin
        pat_used = k;
        break;
      end
    end
    for (int unsigned k = 0; k < RegBytes; k++) packed_pat[8*k +: 8] = pat[k];
    set_config(packed_pat[63:0], packed_pat[127:64], PatLenW'(len), LimitW'(lim));

    quota = sent_cnt + BeatsTarget / PhaseCount;
    // long receiver hold-off while beats keep coming, so the input backs up
    if (ph == 6) hold_req = 1'b1;
    while (sent_cnt < quota) begin
      if ($urandom_range(99) < 8) begin
        repeat ($urandom_range(8, 1))
          send_beat(8'($urandom_range(255)), $urandom_range(99) < 25);
      end else begin
        send_text();
      end
      if (ph == 7 && $urandom_range(99) < 10) drain();
    end
  endtask

  initial begin
    logic [127:0] long_pat;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = CFG_PATTERN_LOW;
    cfg_wdata = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // out of reset: empty pattern with zero limit, found on the first byte
    send_beat(8'h41, 1'b0);
    send_beat(8'h42, 1'b0);
    send_beat(8'h00, 1'b1);
    drain();
    set_config(64'h6261, 64'h0, 5'd2, 16'hFFFF);
    send_str("xab");
    send_beat(8'h61, 1'b1);
    send_beat(8'h00, 1'b0);
    drain();
    // match that ends on the last byte the limit allows, then a miss there
    set_config(64'h636261, 64'h0, 5'd3, 16'd3);
    send_str("abc");
    send_str("xab");
    drain();
    set_config(64'h636261, 64'h0, 5'd3, 16'd0);
    send_str("a");
    drain();
    // pattern cut short by a zero byte inside it
    set_config(64'h6300_6261, 64'h0, 5'd4, 16'd100);
    send_str("zab");
    drain();
    // over-long length saturates to a full 16 byte pattern
    for (int k = 0; k < 16; k++) long_pat[8*k +: 8] = 8'hFF - k;
    set_config(long_pat[63:0], long_pat[127:64], 5'd31, 16'hFFFF);
    for (int k = 0; k < 16; k++) send_beat(8'hFF - k, k == 0);

    for (int unsigned ph = 0; ph < PhaseCount; ph++) run_phase(ph);
    drain();

    $display("run covered %0d examined text beats under %0d register settings,",
             examined, settings_cnt);
    $display("with %0d found and %0d not found results", found_cnt, not_found_cnt);
    if (err_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
